// ----- hdl/edf_cbs_deadline_scheduler_macros.svh -----
// Assertion shorthands for the deadline scheduler.
`ifndef EDF_CBS_DEADLINE_SCHEDULER_MACROS_SVH
`define EDF_CBS_DEADLINE_SCHEDULER_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define EDFCBS_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// A condition that, when true, must be met by a second one at the same edge.
`define EDFCBS_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hdl/edfcbs_pkg.sv -----
package edfcbs_pkg;

  // Default size of the entity table.
  localparam int ENTITIES_DEF = 16;

  // Operation codes carried in the mode field.
  localparam logic [2:0] MODE_SETUP  = 3'd0;
  localparam logic [2:0] MODE_WAKEUP = 3'd1;
  localparam logic [2:0] MODE_SLEEP  = 3'd2;
  localparam logic [2:0] MODE_TICK   = 3'd3;
  localparam logic [2:0] MODE_PICK   = 3'd4;
  localparam logic [2:0] MODE_YIELD  = 3'd5;
  localparam logic [2:0] MODE_TIMER  = 3'd6;
  localparam logic [2:0] MODE_FORK   = 3'd7;

  // Bit positions in the per-entity flags.
  localparam int FLAG_NEW = 0;
  localparam int FLAG_THR = 1;
  localparam int FLAG_ACT = 2;
  localparam int FLAG_QUE = 3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  entity_index;
    logic [63:0] now;
    logic [31:0] budget;
    logic [31:0] relative_deadline;
  } in_item_t;

  typedef struct packed {
    logic        picked_valid;
    logic [3:0]  picked_entity;
    logic        resched;
    logic        timer_arm;
    logic [3:0]  timer_entity;
    logic [63:0] timer_expiry;
  } out_item_t;

  // One row of the entity table memory.
  typedef struct packed {
    logic [31:0] max_budget;
    logic [31:0] period;
    logic [63:0] runtime;
    logic [63:0] deadline;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  // True when a lies before b on the wrapping 64-bit clock.
  function automatic logic t_before(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    return d[63];
  endfunction

  // True when a two's complement runtime is zero or negative.
  function automatic logic non_positive(input logic [63:0] r);
    return (r == 64'd0) || r[63];
  endfunction

endpackage

// ----- hdl/edfcbs_ram.sv -----
module edfcbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/edf_cbs_deadline_scheduler.sv -----
// Earliest-deadline-first scheduler with a constant-bandwidth budget per entity.
// Input channel (in_valid, in_stall, in_data): one item is one scheduler event
// (setup, wakeup, sleep, tick, pick, yield, timer expiry or fork). Every item
// produces exactly one result item on the output channel (out_valid, out_stall,
// out_data) giving the picked entity, the reschedule request and any timer to arm.
// The entity table sits in a single-port-write, registered-read memory; the logic
// reads an entry, works on it in registers and writes it back.
// A wakeup runs the bandwidth check on the shared multiplier, a replenishment from
// a timer expiry or a charging tick runs the 64-step restoring divider, and a pick
// scans all ENTITIES entries through the memory port. One item is worked on
// at a time; in_stall is high from acceptance until the result is placed in the
// output register. The output register lets a new item be accepted while the last
// result waits. When out_stall is held, the finished result waits in the state
// before the output and the block takes no further item.
// Reset clears all flags, the running entity, the queue count and the entry
// valid bits, so every entry reads as zero until it is first written.
`include "edf_cbs_deadline_scheduler_macros.svh"

module edf_cbs_deadline_scheduler #(
  parameter int ENTITIES = edfcbs_pkg::ENTITIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  edfcbs_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output edfcbs_pkg::out_item_t out_data
);

  import edfcbs_pkg::*;

  localparam int IDX_W = $clog2(ENTITIES);
  localparam int CNT_W = $clog2(ENTITIES + 1);

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_SETUP   = 18'h00002,
    S_LD      = 18'h00004,
    S_CHGST   = 18'h00008,
    S_CHG     = 18'h00010,
    S_CHG2    = 18'h00020,
    S_ENQ     = 18'h00040,
    S_DIV     = 18'h00080,
    S_MUL     = 18'h00100,
    S_REPL2   = 18'h00200,
    S_RCHK    = 18'h00400,
    S_UPD     = 18'h00800,
    S_WB      = 18'h01000,
    S_PRE     = 18'h02000,
    S_POST    = 18'h04000,
    S_SCAN    = 18'h08000,
    S_PICKEND = 18'h10000,
    S_OUT     = 18'h20000
  } state_t;

  typedef enum logic [1:0] {
    MSEL_QPER,
    MSEL_LEFT,
    MSEL_RIGHT
  } msel_t;

  state_t             state_r, state_nxt;
  logic [2:0]         mode_r, mode_nxt;
  logic [IDX_W-1:0]   eidx_r, eidx_nxt;
  logic [63:0]        now_r, now_nxt;
  logic [31:0]        bud_r, bud_nxt;
  logic [31:0]        rdl_r, rdl_nxt;
  logic               chg_r, chg_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [31:0]        mb_r, mb_nxt;
  logic [31:0]        per_r, per_nxt;
  logic [63:0]        rt_r, rt_nxt;
  logic [63:0]        dl_r, dl_nxt;
  logic [63:0]        quo_r, quo_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [31:0]        ymul_r, ymul_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic [63:0]        left_r, left_nxt;
  logic [5:0]         dcnt_r, dcnt_nxt;
  logic [1:0]         mstep_r, mstep_nxt;
  msel_t              msel_r, msel_nxt;
  logic [IDX_W-1:0]   sidx_r, sidx_nxt;
  logic [IDX_W-1:0]   best_r, best_nxt;
  logic [63:0]        best_dl_r, best_dl_nxt;
  logic               found_r, found_nxt;
  out_item_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  logic               run_v_r, run_v_nxt;
  logic [IDX_W-1:0]   run_e_r, run_e_nxt;
  logic [63:0]        start_r, start_nxt;
  logic [CNT_W-1:0]   qcnt_r, qcnt_nxt;
  logic [3:0]         flags_r [ENTITIES];
  logic [3:0]         flags_nxt [ENTITIES];
  logic [ENTITIES-1:0] vld_r, vld_nxt;
  logic               rd_vld_r, rd_vld_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENT_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENT_W-1:0]   ram_rdata;
  ent_t               rd_ent;
  logic [31:0]        mul_a;
  logic [63:0]        mprod;
  logic [ENTITIES-1:0] que_vec;

  edfcbs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTITIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Entries never written read as zero.
  assign rd_ent = rd_vld_r ? ent_t'(ram_rdata) : '0;

  // Shared 32x32 multiplier, low half of the operand first.
  assign mul_a = (mstep_r == 2'd0) ? quo_r[31:0] : quo_r[63:32];
  assign mprod = mul_a * ymul_r;

  always_comb begin
    for (int i = 0; i < ENTITIES; i++) begin
      que_vec[i] = flags_r[i][FLAG_QUE];
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Event sequencer.
  always_comb begin
    logic [3:0]       fl;
    logic             idx_ok;
    logic [IDX_W-1:0] ein;
    logic             dmiss;
    logic             rorun;
    logic             repl;
    logic [63:0]      delta;
    logic [32:0]      t33;
    logic             ge;
    logic [63:0]      sum64;

    state_nxt     = state_r;
    mode_nxt      = mode_r;
    eidx_nxt      = eidx_r;
    now_nxt       = now_r;
    bud_nxt       = bud_r;
    rdl_nxt       = rdl_r;
    chg_nxt       = chg_r;
    cur_nxt       = cur_r;
    mb_nxt        = mb_r;
    per_nxt       = per_r;
    rt_nxt        = rt_r;
    dl_nxt        = dl_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    ymul_nxt      = ymul_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    left_nxt      = left_r;
    dcnt_nxt      = dcnt_r;
    mstep_nxt     = mstep_r;
    msel_nxt      = msel_r;
    sidx_nxt      = sidx_r;
    best_nxt      = best_r;
    best_dl_nxt   = best_dl_r;
    found_nxt     = found_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    run_v_nxt     = run_v_r;
    run_e_nxt     = run_e_r;
    start_nxt     = start_r;
    qcnt_nxt      = qcnt_r;
    flags_nxt     = flags_r;
    vld_nxt       = vld_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = {mb_r, per_r, rt_r, dl_r};
    rd_addr       = '0;
    fl            = '0;
    idx_ok        = 1'b0;
    ein           = '0;
    dmiss         = 1'b0;
    rorun         = 1'b0;
    repl          = 1'b0;
    delta         = '0;
    t33           = '0;
    ge            = 1'b0;
    sum64         = '0;

    // The output register empties when its item is taken.
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ein       = IDX_W'(in_data.entity_index);
          idx_ok    = {28'd0, in_data.entity_index} < 32'(ENTITIES);
          mode_nxt  = in_data.mode;
          eidx_nxt  = ein;
          cur_nxt   = ein;
          now_nxt   = in_data.now;
          bud_nxt   = in_data.budget;
          rdl_nxt   = in_data.relative_deadline;
          res_nxt   = '0;
          chg_nxt   = 1'b0;
          rd_addr   = ein;
          state_nxt = S_OUT;
          if (idx_ok) begin
            fl = flags_r[ein];
          end
          case (in_data.mode)
            MODE_SETUP: begin
              if (idx_ok) begin
                fl[FLAG_NEW]   = 1'b1;
                fl[FLAG_THR]   = 1'b0;
                flags_nxt[ein] = fl;
                state_nxt      = S_SETUP;
              end
            end
            MODE_WAKEUP: begin
              if (idx_ok) begin
                if (!fl[FLAG_THR] && !fl[FLAG_QUE]) begin
                  state_nxt = S_LD;
                end
                fl[FLAG_ACT]   = 1'b1;
                flags_nxt[ein] = fl;
              end
            end
            MODE_SLEEP: begin
              if (idx_ok) begin
                state_nxt = S_CHGST;
              end
            end
            MODE_TICK, MODE_PICK: begin
              state_nxt = S_CHGST;
            end
            MODE_YIELD: begin
              if (run_v_r) begin
                cur_nxt   = run_e_r;
                rd_addr   = run_e_r;
                state_nxt = S_LD;
              end
            end
            MODE_TIMER: begin
              if (idx_ok) begin
                if (fl[FLAG_ACT] && !fl[FLAG_QUE]) begin
                  state_nxt = S_LD;
                end
                fl[FLAG_THR]   = 1'b0;
                flags_nxt[ein] = fl;
              end
            end
            default: begin
              if (idx_ok) begin
                fl[FLAG_THR]   = 1'b1;
                fl[FLAG_NEW]   = 1'b0;
                flags_nxt[ein] = fl;
              end
            end
          endcase
        end
      end

      // Setup keeps runtime and deadline and loads budget and period.
      S_SETUP: begin
        ram_we    = 1'b1;
        ram_waddr = eidx_r;
        ram_wdata = {bud_r, rdl_r, rd_ent.runtime, rd_ent.deadline};
        state_nxt = S_OUT;
      end

      // Charging starts only for a running entity that is queued.
      S_CHGST: begin
        if (run_v_r && flags_r[run_e_r][FLAG_QUE]) begin
          cur_nxt   = run_e_r;
          rd_addr   = run_e_r;
          chg_nxt   = 1'b1;
          state_nxt = S_LD;
        end else begin
          state_nxt = S_POST;
        end
      end

      S_LD: begin
        mb_nxt  = rd_ent.max_budget;
        per_nxt = rd_ent.period;
        rt_nxt  = rd_ent.runtime;
        dl_nxt  = rd_ent.deadline;
        if (chg_r) begin
          state_nxt = S_CHG;
        end else if (mode_r == MODE_YIELD) begin
          // A yielding entity with budget left gives it up and starts afresh.
          if (!non_positive(rd_ent.runtime)) begin
            flags_nxt[cur_r][FLAG_NEW] = 1'b1;
            rt_nxt = '0;
          end
          if (flags_r[cur_r][FLAG_QUE]) begin
            chg_nxt   = 1'b1;
            state_nxt = S_CHG;
          end else begin
            state_nxt = S_WB;
          end
        end else begin
          state_nxt = S_ENQ;
        end
      end

      // Charge the time run since the last start; negative time counts as none.
      S_CHG: begin
        delta = now_r - start_r;
        if (delta[63]) begin
          delta = '0;
        end
        rt_nxt    = rt_r - delta;
        start_nxt = now_r;
        state_nxt = S_CHG2;
      end

      // Overrun or deadline miss: throttle with a timer, or replenish at once.
      S_CHG2: begin
        dmiss = t_before(dl_r, now_r);
        rorun = non_positive(rt_r);
        if (!rorun && !dmiss) begin
          state_nxt = S_WB;
        end else begin
          fl = flags_r[cur_r];
          if (dmiss) begin
            rt_nxt = (rorun ? rt_r : 64'd0) - (now_r - dl_r);
          end
          fl[FLAG_QUE]    = 1'b0;
          qcnt_nxt        = qcnt_r - CNT_W'(1);
          res_nxt.resched = 1'b1;
          if (!dmiss) begin
            fl[FLAG_THR]         = 1'b1;
            res_nxt.timer_arm    = 1'b1;
            res_nxt.timer_entity = 4'(cur_r);
            res_nxt.timer_expiry = dl_r;
            state_nxt            = S_WB;
          end else begin
            state_nxt = S_ENQ;
          end
          flags_nxt[cur_r] = fl;
        end
      end

      // Enqueue: replenish, renew a new entity, or run the bandwidth check.
      S_ENQ: begin
        fl   = flags_r[cur_r];
        repl = chg_r || (mode_r == MODE_TIMER);
        if (fl[FLAG_THR] || fl[FLAG_QUE]) begin
          state_nxt = S_WB;
        end else begin
          fl[FLAG_QUE] = 1'b1;
          qcnt_nxt     = qcnt_r + CNT_W'(1);
          if (!fl[FLAG_NEW] && repl) begin
            if (non_positive(rt_r) && (mb_r != 32'd0)) begin
              quo_nxt   = 64'd0 - rt_r;
              rem_nxt   = '0;
              dcnt_nxt  = '0;
              state_nxt = S_DIV;
            end else begin
              state_nxt = S_RCHK;
            end
          end else if (fl[FLAG_NEW]) begin
            dl_nxt       = now_r + {32'd0, per_r};
            rt_nxt       = {32'd0, mb_r};
            fl[FLAG_NEW] = 1'b0;
            state_nxt    = S_WB;
          end else begin
            quo_nxt   = rt_r;
            ymul_nxt  = per_r;
            msel_nxt  = MSEL_LEFT;
            mstep_nxt = 2'd0;
            state_nxt = S_MUL;
          end
          flags_nxt[cur_r] = fl;
        end
      end

      // Restoring division of the overdraft by the budget, one bit a cycle.
      S_DIV: begin
        t33      = {rem_r, quo_r[63]};
        ge       = t33 >= {1'b0, mb_r};
        rem_nxt  = ge ? 32'(t33 - {1'b0, mb_r}) : t33[31:0];
        quo_nxt  = {quo_r[62:0], ge};
        dcnt_nxt = dcnt_r + 6'd1;
        if (dcnt_r == 6'd63) begin
          ymul_nxt  = per_r;
          msel_nxt  = MSEL_QPER;
          mstep_nxt = 2'd0;
          state_nxt = S_MUL;
        end
      end

      // Low 64 bits of a 64 by 32 product, built from the two 32-bit partial products.
      S_MUL: begin
        case (mstep_r)
          2'd0: begin
            prod_nxt  = mprod;
            mstep_nxt = 2'd1;
          end
          2'd1: begin
            acc_nxt   = prod_r;
            prod_nxt  = mprod;
            mstep_nxt = 2'd2;
          end
          2'd2: begin
            sum64     = acc_r + {prod_r[31:0], 32'd0};
            mstep_nxt = 2'd0;
            case (msel_r)
              MSEL_QPER: begin
                acc_nxt   = sum64;
                state_nxt = S_REPL2;
              end
              MSEL_LEFT: begin
                left_nxt = sum64;
                quo_nxt  = dl_r - now_r;
                ymul_nxt = mb_r;
                msel_nxt = MSEL_RIGHT;
              end
              default: begin
                acc_nxt   = sum64;
                state_nxt = S_UPD;
              end
            endcase
          end
          default: begin
            mstep_nxt = 2'd0;
          end
        endcase
      end

      // Apply the quotient: whole periods are added to the deadline.
      S_REPL2: begin
        rt_nxt    = {32'd0, mb_r} - {32'd0, rem_r};
        dl_nxt    = dl_r + acc_r + {32'd0, per_r};
        state_nxt = S_RCHK;
      end

      // Still late after replenishment: start a fresh instance.
      S_RCHK: begin
        if (t_before(dl_r, now_r)) begin
          dl_nxt = now_r + {32'd0, per_r};
          rt_nxt = {32'd0, mb_r};
        end
        state_nxt = S_WB;
      end

      // Renew when the deadline has passed or the bandwidth would overflow.
      S_UPD: begin
        if (t_before(dl_r, now_r) || t_before(acc_r, left_r)) begin
          dl_nxt = now_r + {32'd0, per_r};
          rt_nxt = {32'd0, mb_r};
        end
        state_nxt = S_WB;
      end

      S_WB: begin
        ram_we = 1'b1;
        if (chg_r) begin
          state_nxt = S_POST;
        end else if (mode_r == MODE_YIELD) begin
          state_nxt = S_OUT;
        end else if (!run_v_r) begin
          res_nxt.resched = 1'b1;
          state_nxt       = S_OUT;
        end else if (run_e_r == cur_r) begin
          state_nxt = S_OUT;
        end else begin
          rd_addr   = run_e_r;
          state_nxt = S_PRE;
        end
      end

      // Preempt when the woken entity's deadline is earlier.
      S_PRE: begin
        if (t_before(dl_r, rd_ent.deadline)) begin
          res_nxt.resched = 1'b1;
        end
        state_nxt = S_OUT;
      end

      S_POST: begin
        case (mode_r)
          MODE_SLEEP: begin
            fl = flags_r[eidx_r];
            if (fl[FLAG_QUE]) begin
              qcnt_nxt = qcnt_r - CNT_W'(1);
            end
            fl[FLAG_QUE]      = 1'b0;
            fl[FLAG_ACT]      = 1'b0;
            flags_nxt[eidx_r] = fl;
            if (run_v_r && (run_e_r == eidx_r)) begin
              run_v_nxt       = 1'b0;
              res_nxt.resched = 1'b1;
            end
            state_nxt = S_OUT;
          end
          MODE_PICK: begin
            rd_addr   = '0;
            sidx_nxt  = '0;
            found_nxt = 1'b0;
            state_nxt = S_SCAN;
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end

      // Scan the table one entry a cycle; ties stay with the lower index.
      S_SCAN: begin
        if (flags_r[sidx_r][FLAG_QUE] &&
            (!found_r || t_before(rd_ent.deadline, best_dl_r))) begin
          best_nxt    = sidx_r;
          best_dl_nxt = rd_ent.deadline;
          found_nxt   = 1'b1;
        end
        if (sidx_r == IDX_W'(ENTITIES - 1)) begin
          state_nxt = S_PICKEND;
        end else begin
          sidx_nxt = sidx_r + IDX_W'(1);
          rd_addr  = sidx_r + IDX_W'(1);
        end
      end

      S_PICKEND: begin
        run_v_nxt = found_r;
        if (found_r) begin
          run_e_nxt             = best_r;
          start_nxt             = now_r;
          res_nxt.picked_valid  = 1'b1;
          res_nxt.picked_entity = 4'(best_r);
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (ram_we) begin
      vld_nxt[ram_waddr] = 1'b1;
    end
    rd_vld_nxt = vld_r[rd_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      run_v_r     <= 1'b0;
      run_e_r     <= '0;
      start_r     <= '0;
      qcnt_r      <= '0;
      vld_r       <= '0;
      for (int i = 0; i < ENTITIES; i++) begin
        flags_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      run_v_r     <= run_v_nxt;
      run_e_r     <= run_e_nxt;
      start_r     <= start_nxt;
      qcnt_r      <= qcnt_nxt;
      vld_r       <= vld_nxt;
      flags_r     <= flags_nxt;
    end
  end

  // Working registers and payload.
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    eidx_r     <= eidx_nxt;
    now_r      <= now_nxt;
    bud_r      <= bud_nxt;
    rdl_r      <= rdl_nxt;
    chg_r      <= chg_nxt;
    cur_r      <= cur_nxt;
    mb_r       <= mb_nxt;
    per_r      <= per_nxt;
    rt_r       <= rt_nxt;
    dl_r       <= dl_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    ymul_r     <= ymul_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    left_r     <= left_nxt;
    dcnt_r     <= dcnt_nxt;
    mstep_r    <= mstep_nxt;
    msel_r     <= msel_nxt;
    sidx_r     <= sidx_nxt;
    best_r     <= best_nxt;
    best_dl_r  <= best_dl_nxt;
    found_r    <= found_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    rd_vld_r   <= rd_vld_nxt;
  end

  // The queue count always matches the number of queued flags.
  `EDFCBS_ASSERT_ALWAYS(a_qcnt, clk, rst_n, $countones(que_vec) == int'(qcnt_r), "queue count out of step with flags")

  // A timer is only armed together with a reschedule request.
  `EDFCBS_ASSERT_IMPLIES(a_timer_resched, clk, rst_n, out_valid_r && out_data_r.timer_arm, out_data_r.resched, "timer armed without reschedule")

  // A pick result names the entity that now runs.
  `EDFCBS_ASSERT_IMPLIES(a_pick_run, clk, rst_n, state_r == S_OUT && res_r.picked_valid, run_v_r && (res_r.picked_entity == 4'(run_e_r)), "picked entity is not the running one")

endmodule

// ----- sim/edf_sched_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the deadline scheduler, works out the result of
// every accepted item and compares it with what the block returns.
module edf_sched_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  edfcbs_pkg::in_item_t  in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  edfcbs_pkg::out_item_t out_data,
  output int                    fail_count,
  output int                    awaited_count,
  output int                    checked_count,
  output int                    resched_count,
  output int                    timer_count,
  output int                    pick_count
);

  import edfcbs_pkg::*;

  localparam int NENT = ENTITIES_DEF;

  // Shadow copy of the entity table and the running state.
  logic [31:0] ent_budget   [NENT];
  logic [31:0] ent_period   [NENT];
  logic [63:0] ent_runtime  [NENT];
  logic [63:0] ent_deadline [NENT];
  logic [3:0]  ent_flags    [NENT];
  logic        run_valid;
  logic [3:0]  run_idx;
  logic [63:0] run_since;
  int          nqueued;
  out_item_t   outcome;

  out_item_t awaited_results[$];

  // True when a lies before b on the wrapping clock.
  function automatic logic earlier(logic [63:0] a, logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    return d[63];
  endfunction

  function automatic logic not_positive(logic [63:0] r);
    return (r == 64'd0) || r[63];
  endfunction

  function void renew_ent(int e, logic [63:0] now);
    ent_deadline[e] = now + {32'd0, ent_period[e]};
    ent_runtime[e]  = {32'd0, ent_budget[e]};
  endfunction

  // Closed-form replenishment, falling back to a fresh instance when still late.
  function void replenish_ent(int e, logic [63:0] now);
    logic [63:0] r, mb, n;
    r  = ent_runtime[e];
    mb = {32'd0, ent_budget[e]};
    if (not_positive(r) && mb != 64'd0) begin
      n = (64'd0 - r) / mb + 64'd1;
      ent_runtime[e]  = r + n * mb;
      ent_deadline[e] = ent_deadline[e] + n * {32'd0, ent_period[e]};
    end
    if (earlier(ent_deadline[e], now))
      renew_ent(e, now);
  endfunction

  // Bandwidth check on wakeup.
  function void refresh_ent(int e, logic [63:0] now);
    logic [63:0] lhs, rhs;
    if (ent_flags[e][FLAG_NEW]) begin
      renew_ent(e, now);
      ent_flags[e][FLAG_NEW] = 1'b0;
      return;
    end
    lhs = {32'd0, ent_period[e]} * ent_runtime[e];
    rhs = (ent_deadline[e] - now) * {32'd0, ent_budget[e]};
    if (earlier(ent_deadline[e], now) || earlier(rhs, lhs))
      renew_ent(e, now);
  endfunction

  function logic enqueue_ent(int e, logic [63:0] now, logic repl);
    if (ent_flags[e][FLAG_THR] || ent_flags[e][FLAG_QUE])
      return 1'b0;
    if (!ent_flags[e][FLAG_NEW] && repl)
      replenish_ent(e, now);
    else
      refresh_ent(e, now);
    ent_flags[e][FLAG_QUE] = 1'b1;
    nqueued++;
    return 1'b1;
  endfunction

  function void dequeue_ent(int e);
    if (ent_flags[e][FLAG_QUE]) begin
      ent_flags[e][FLAG_QUE] = 1'b0;
      nqueued--;
    end
  endfunction

  function logic preempts_running(int e);
    if (!run_valid)
      return 1'b1;
    return earlier(ent_deadline[e], ent_deadline[run_idx]);
  endfunction

  // Charges the running entity and handles an overrun or a missed deadline.
  function void charge_running(logic [63:0] now);
    int          r;
    logic [63:0] delta, dl;
    logic        dmiss, overrun;
    r = run_idx;
    if (!run_valid || !ent_flags[r][FLAG_QUE])
      return;
    delta = now - run_since;
    if (delta[63])
      delta = 64'd0;
    run_since = now;
    ent_runtime[r] = ent_runtime[r] - delta;
    dl = ent_deadline[r];
    dmiss = earlier(dl, now);
    overrun = not_positive(ent_runtime[r]);
    if (!overrun && !dmiss)
      return;
    if (dmiss) begin
      if (!overrun)
        ent_runtime[r] = 64'd0;
      ent_runtime[r] = ent_runtime[r] - (now - dl);
    end
    dequeue_ent(r);
    if (!earlier(dl, now)) begin
      ent_flags[r][FLAG_THR] = 1'b1;
      outcome.timer_arm    = 1'b1;
      outcome.timer_entity = run_idx;
      outcome.timer_expiry = dl;
    end else begin
      void'(enqueue_ent(r, now, 1'b1));
    end
    outcome.resched = 1'b1;
  endfunction

  // Applies one event to the shadow state and returns its result.
  function out_item_t schedule_event(in_item_t it);
    int   e;
    logic found;
    int   best;
    e = it.entity_index;
    outcome = '0;
    case (it.mode)
      MODE_SETUP: begin
        ent_budget[e] = it.budget;
        ent_period[e] = it.relative_deadline;
        ent_flags[e][FLAG_NEW] = 1'b1;
        ent_flags[e][FLAG_THR] = 1'b0;
      end
      MODE_WAKEUP: begin
        ent_flags[e][FLAG_ACT] = 1'b1;
        if (enqueue_ent(e, it.now, 1'b0) && preempts_running(e))
          outcome.resched = 1'b1;
      end
      MODE_SLEEP: begin
        charge_running(it.now);
        dequeue_ent(e);
        ent_flags[e][FLAG_ACT] = 1'b0;
        if (run_valid && run_idx == e) begin
          run_valid = 1'b0;
          outcome.resched = 1'b1;
        end
      end
      MODE_TICK: charge_running(it.now);
      MODE_PICK: begin
        found = 1'b0;
        best = 0;
        charge_running(it.now);
        for (int i = 0; i < NENT; i++) begin
          if (ent_flags[i][FLAG_QUE] &&
              (!found || earlier(ent_deadline[i], ent_deadline[best]))) begin
            best = i;
            found = 1'b1;
          end
        end
        run_valid = found;
        if (found) begin
          run_idx = 4'(best);
          run_since = it.now;
          outcome.picked_valid  = 1'b1;
          outcome.picked_entity = 4'(best);
        end
      end
      MODE_YIELD: begin
        if (run_valid) begin
          if (!not_positive(ent_runtime[run_idx])) begin
            ent_flags[run_idx][FLAG_NEW] = 1'b1;
            ent_runtime[run_idx] = 64'd0;
          end
          charge_running(it.now);
        end
      end
      MODE_TIMER: begin
        ent_flags[e][FLAG_THR] = 1'b0;
        if (ent_flags[e][FLAG_ACT] && enqueue_ent(e, it.now, 1'b1) &&
            preempts_running(e))
          outcome.resched = 1'b1;
      end
      default: begin
        ent_flags[e][FLAG_THR] = 1'b1;
        ent_flags[e][FLAG_NEW] = 1'b0;
      end
    endcase
    return outcome;
  endfunction

  assign awaited_count = awaited_results.size();

  // Compare each returned item first, then predict the newly accepted one.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < NENT; i++) begin
        ent_budget[i] = '0;
        ent_period[i] = '0;
        ent_runtime[i] = '0;
        ent_deadline[i] = '0;
        ent_flags[i] = '0;
      end
      run_valid = 1'b0;
      run_idx = '0;
      run_since = '0;
      nqueued = 0;
      awaited_results.delete();
      fail_count = 0;
      checked_count = 0;
      resched_count = 0;
      timer_count = 0;
      pick_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        checked_count++;
        if (out_data.resched) resched_count++;
        if (out_data.timer_arm) timer_count++;
        if (out_data.picked_valid) pick_count++;
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Unexpected result item %p", out_data);
        end else begin
          want = awaited_results.pop_front();
          if (want.picked_valid !== out_data.picked_valid ||
              want.picked_entity !== out_data.picked_entity ||
              want.resched !== out_data.resched ||
              want.timer_arm !== out_data.timer_arm ||
              want.timer_entity !== out_data.timer_entity ||
              want.timer_expiry !== out_data.timer_expiry) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Mismatch on result %0d: expected %p, got %p",
                       checked_count, want, out_data);
          end
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(schedule_event(in_data));
    end
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import edfcbs_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 300;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int fail_count, awaited_count, checked_count;
  int resched_count, timer_count, pick_count;

  int          tx_pct;
  int          rx_pct;
  logic        hold_req;
  logic [63:0] clock_ns;
  int          sent_count;
  int          idle_cycles;

  edf_cbs_deadline_scheduler u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  edf_sched_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .awaited_count(awaited_count),
    .checked_count(checked_count),
    .resched_count(resched_count),
    .timer_count  (timer_count),
    .pick_count   (pick_count)
  );

  // Free-running clock, 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one item, with random idle cycles first, and waits for its acceptance.
  task automatic offer(input logic [2:0] mode, input int ent, input logic [63:0] now,
                       input logic [31:0] budget, input logic [31:0] rel_dl);
    in_item_t it;
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.mode = mode;
    it.entity_index = 4'(ent);
    it.now = now;
    it.budget = budget;
    it.relative_deadline = rel_dl;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  // One random event, mostly on a few entities with a clock that moves forward.
  task automatic offer_random();
    int          pick;
    logic [2:0]  mode;
    int          ent;
    logic [31:0] budget, rel_dl;
    pick = $urandom_range(99);
    if (pick < 12) mode = MODE_SETUP;
    else if (pick < 32) mode = MODE_WAKEUP;
    else if (pick < 38) mode = MODE_SLEEP;
    else if (pick < 58) mode = MODE_TICK;
    else if (pick < 78) mode = MODE_PICK;
    else if (pick < 84) mode = MODE_YIELD;
    else if (pick < 96) mode = MODE_TIMER;
    else mode = MODE_FORK;
    ent = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(5);
    // Clock: mostly forward, sometimes a little back, rarely anywhere.
    pick = $urandom_range(99);
    if (pick < 85) clock_ns = clock_ns + $urandom_range(2500);
    else if (pick < 97) clock_ns = clock_ns - $urandom_range(300);
    else clock_ns = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 8) budget = 32'd0;
    else if (pick < 15) budget = $urandom;
    else budget = $urandom_range(3000, 1);
    pick = $urandom_range(99);
    if (pick < 8) rel_dl = $urandom_range(32'hFFFF_FFFF, 1);
    else if (pick < 12) rel_dl = 32'd1;
    else rel_dl = $urandom_range(10000, 1);
    offer(mode, ent, clock_ns, budget, rel_dl);
  endtask

  // Result side: random stalls, and once a long hold-off so the block backs up.
  initial begin
    logic held;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rx_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and verdict.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_req = 1'b0;
    tx_pct = 10;
    rx_pct = 52;
    clock_ns = 64'd1000;
    sent_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: extremes, every operation and the corner cases.
    offer(MODE_TICK, 0, 64'd0, '0, 32'd1);
    offer(MODE_PICK, 0, 64'd10, '0, 32'd1);
    offer(MODE_YIELD, 0, 64'd20, '0, 32'd1);
    offer(MODE_SETUP, 0, 64'd30, 32'd0, 32'd1);
    offer(MODE_SETUP, 15, 64'd40, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(MODE_SETUP, 2, 64'd50, 32'd1000, 32'd5000);
    offer(MODE_WAKEUP, 2, 64'd100, '0, 32'd1);
    offer(MODE_WAKEUP, 2, 64'd110, '0, 32'd1);
    offer(MODE_WAKEUP, 15, 64'd120, '0, 32'd1);
    offer(MODE_WAKEUP, 0, 64'd130, '0, 32'd1);
    offer(MODE_PICK, 0, 64'd140, '0, 32'd1);
    offer(MODE_TICK, 0, 64'd100, '0, 32'd1);
    offer(MODE_TICK, 0, 64'd1500, '0, 32'd1);
    offer(MODE_TIMER, 2, 64'd6000, '0, 32'd1);
    offer(MODE_PICK, 0, 64'd6010, '0, 32'd1);
    offer(MODE_TICK, 0, 64'd90000, '0, 32'd1);
    offer(MODE_YIELD, 0, 64'd90100, '0, 32'd1);
    offer(MODE_FORK, 7, 64'd90200, '0, 32'd1);
    offer(MODE_WAKEUP, 7, 64'd90300, '0, 32'd1);
    offer(MODE_TIMER, 7, 64'd90400, '0, 32'd1);
    offer(MODE_TIMER, 9, 64'd90500, '0, 32'd1);
    offer(MODE_PICK, 0, 64'hFFFF_FFFF_FFFF_FF00, '0, 32'd1);
    offer(MODE_TICK, 0, 64'h0000_0000_0000_0100, '0, 32'd1);
    offer(MODE_SLEEP, 15, 64'h0000_0000_0000_0200, '0, 32'd1);
    offer(MODE_SLEEP, 2, 64'h0000_0000_0000_0300, '0, 32'd1);
    clock_ns = 64'h0000_0000_0000_0400;

    // Random part in three idling phases.
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        tx_pct = 52;
        rx_pct = 10;
      end else if (phase == 2) begin
        tx_pct = 0;
        rx_pct = 0;
        hold_req <= 1'b1;
      end
      repeat (PHASE_ITEMS) offer_random();
    end
    in_valid <= 1'b0;

    while (awaited_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d events, checked %0d results: %0d picks, %0d reschedules, %0d timers.",
             sent_count, checked_count, pick_count, resched_count, timer_count);
    if (fail_count == 0 && awaited_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
